// ===== rtl/tspl_pkg.sv =====
// tspl_pkg: shared constants, codes and types for the triangle strip point locator.
// No dependencies; imported by tspl_area and triangle_strip_point_locator_core.
package tspl_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int MIN_VERTICES     = 3;

  localparam int VCOUNT_BITS    = 7;
  localparam int SLACK_BITS     = 20;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd40;
  localparam logic [SLACK_BITS-1:0]  SLACK_RESET  = 20'd13107;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_SLACK   = 1'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // sub-area order inside one triangle test
  localparam logic [1:0] STEP_ABC = 2'd0;
  localparam logic [1:0] STEP_ABP = 2'd1;
  localparam logic [1:0] STEP_APC = 2'd2;
  localparam logic [1:0] STEP_PBC = 2'd3;

  // read tags: which vertex a table read fetches
  localparam logic [2:0] TAG_CUR0 = 3'd0;
  localparam logic [2:0] TAG_CUR1 = 3'd1;
  localparam logic [2:0] TAG_CUR2 = 3'd2;
  localparam logic [2:0] TAG_CUR3 = 3'd3;
  localparam logic [2:0] TAG_PREV = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_FILL,
    ST_START,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    TRIAL_CUR,
    TRIAL_NXT,
    TRIAL_PRV
  } trial_t;

  typedef struct packed {
    logic done;
    logic hit;
  } area_status_t;

endpackage

// ===== rtl/tspl_ram.sv =====
// tspl_ram: generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tspl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tspl_area.sv =====
// tspl_area: pipelined doubled-area test of one triangle against a point.
// Depends on tspl_pkg; two multipliers, one sub-area issued per cycle.
module tspl_area #(
  parameter int COORD_BITS = tspl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [COORD_BITS-1:0]        a_x,
  input  logic signed [COORD_BITS-1:0]        a_z,
  input  logic signed [COORD_BITS-1:0]        b_x,
  input  logic signed [COORD_BITS-1:0]        b_z,
  input  logic signed [COORD_BITS-1:0]        c_x,
  input  logic signed [COORD_BITS-1:0]        c_z,
  input  logic signed [COORD_BITS-1:0]        p_x,
  input  logic signed [COORD_BITS-1:0]        p_z,
  input  logic [tspl_pkg::SLACK_BITS-1:0]     slack,
  output tspl_pkg::area_status_t              status
);
  import tspl_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int AW = (2 * COORD_BITS + 4 > SLACK_BITS + 1) ? 2 * COORD_BITS + 4
                                                            : SLACK_BITS + 1;

  logic                  issuing;
  logic [1:0]            cnt;
  logic                  v1, v2, cmp_go, done_q, hit_q;
  logic [1:0]            t1, t2;
  logic signed [COORD_BITS-1:0] e0_x, e0_z, e1_x, e1_z, e2_x, e2_z;
  logic signed [DW-1:0]  d10_x, d10_z, d20_x, d20_z;
  logic signed [PW-1:0]  prod_p, prod_q;
  logic signed [PW:0]    dpq, dqp;
  logic [AW-1:0]         absd, whole, sum;

  always_comb begin
    e0_x = a_x; e0_z = a_z;
    e1_x = b_x; e1_z = b_z;
    e2_x = c_x; e2_z = c_z;
    case (cnt)
      STEP_ABC: begin
      end
      STEP_ABP: begin
        e2_x = p_x; e2_z = p_z;
      end
      STEP_APC: begin
        e1_x = p_x; e1_z = p_z;
      end
      STEP_PBC: begin
        e0_x = p_x; e0_z = p_z;
      end
      default: begin
      end
    endcase
  end

  assign d10_x = $signed({e1_x[COORD_BITS-1], e1_x}) - $signed({e0_x[COORD_BITS-1], e0_x});
  assign d10_z = $signed({e1_z[COORD_BITS-1], e1_z}) - $signed({e0_z[COORD_BITS-1], e0_z});
  assign d20_x = $signed({e2_x[COORD_BITS-1], e2_x}) - $signed({e0_x[COORD_BITS-1], e0_x});
  assign d20_z = $signed({e2_z[COORD_BITS-1], e2_z}) - $signed({e0_z[COORD_BITS-1], e0_z});

  assign dpq = $signed({prod_p[PW-1], prod_p}) - $signed({prod_q[PW-1], prod_q});
  assign dqp = $signed({prod_q[PW-1], prod_q}) - $signed({prod_p[PW-1], prod_p});

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      cnt     <= STEP_ABC;
      v1      <= 1'b0;
      v2      <= 1'b0;
      cmp_go  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1     <= issuing;
      v2     <= v1;
      cmp_go <= v2 && (t2 == STEP_PBC);
      done_q <= cmp_go;
      if (start) begin
        issuing <= 1'b1;
        cnt     <= STEP_ABC;
      end else if (issuing) begin
        cnt <= cnt + 2'd1;
        if (cnt == STEP_PBC) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    t1     <= cnt;
    t2     <= t1;
    prod_p <= d10_x * d20_z;
    prod_q <= d20_x * d10_z;
    absd   <= dpq[PW] ? AW'($unsigned(dqp)) : AW'($unsigned(dpq));
    if (v2) begin
      case (t2)
        STEP_ABC: whole <= absd + AW'(slack);
        STEP_ABP: sum   <= absd;
        default:  sum   <= sum + absd;
      endcase
    end
    if (cmp_go) begin
      hit_q <= (sum <= whole);
    end
  end

  assign status = '{done: done_q, hit: hit_q};

endmodule

// ===== rtl/triangle_strip_point_locator_core.sv =====
// triangle_strip_point_locator_core: top level, vertex table, query sequencer and result register.
// Depends on tspl_pkg, tspl_ram and tspl_area.
//
//  channel  signals                               dir  accepted when
//  in       in_valid in_stall cmd vertex_index    in   in_valid && !in_stall
//           pos_x pos_z
//  out      out_valid out_stall inside_res        out  out_valid && !out_stall
//           triangle_index
//  cfg      cfg_write cfg_index cfg_data          in   cfg_write
//
// A load writes the table directly. A query reads the current triangle and, on a miss,
// the next, then the previous one: three to five reads through the single table read
// port in all, and one test per triangle in the two-multiplier area unit. Input stalls
// for the whole query. The result waits in an output register; input reopens once
// it is loaded. Reset is synchronous: current triangle 0, vertex_count 40,
// area_slack 13107.
module triangle_strip_point_locator_core #(
  parameter int MAX_VERTICES = tspl_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = tspl_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tspl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tspl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]       vertex_index,
  input  logic signed [COORD_BITS-1:0]          pos_x,
  input  logic signed [COORD_BITS-1:0]          pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  inside_res,
  output logic [$clog2(MAX_VERTICES)-1:0]       triangle_index
);
  import tspl_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  state_t               state, state_next;
  trial_t               trial;
  logic [VCOUNT_BITS-1:0] vertex_count;
  logic [SLACK_BITS-1:0]  area_slack;
  logic [IW-1:0]        cur_tri, cur_r, rd_addr, res_idx, nxt_idx, prv_idx, cur_eff;
  logic [NW-1:0]        n_r, n_eff;
  logic [2:0]           rtag, rtag_q;
  logic                 rd_v_q, res_hit;
  logic                 in_accept, ram_we, ram_re, area_start, out_load;
  logic [2*COORD_BITS-1:0] ram_rdata;
  logic signed [COORD_BITS-1:0] px_r, pz_r;
  logic signed [COORD_BITS-1:0] vx [5];
  logic signed [COORD_BITS-1:0] vz [5];
  logic signed [COORD_BITS-1:0] a_x, a_z, b_x, b_z, c_x, c_z;
  area_status_t         area_st;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x, input logic [NW-1:0] n);
    logic [31:0] nx;
    nx = 32'(x) + 32'd1;
    wrap_inc = (nx == 32'(n)) ? '0 : IW'(nx);
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign ram_we    = in_accept && (cmd == CMD_LOAD) && (32'(vertex_index) < 32'(MAX_VERTICES));

  always_comb begin
    if (32'(vertex_count) < 32'(MIN_VERTICES)) begin
      n_eff = NW'(MIN_VERTICES);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
    cur_eff = (32'(cur_tri) < 32'(n_eff)) ? cur_tri : '0;
  end

  assign nxt_idx = wrap_inc(cur_r, n_r);
  assign prv_idx = (cur_r == '0) ? IW'(32'(n_r) - 32'd1) : cur_r - IW'(1);

  tspl_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_strip (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vertex_index),
    .wdata ({pos_x, pos_z}),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (trial)
      TRIAL_NXT: begin
        a_x = vx[TAG_CUR1]; a_z = vz[TAG_CUR1];
        b_x = vx[TAG_CUR2]; b_z = vz[TAG_CUR2];
        c_x = vx[TAG_CUR3]; c_z = vz[TAG_CUR3];
      end
      TRIAL_PRV: begin
        a_x = vx[TAG_PREV]; a_z = vz[TAG_PREV];
        b_x = vx[TAG_CUR0]; b_z = vz[TAG_CUR0];
        c_x = vx[TAG_CUR1]; c_z = vz[TAG_CUR1];
      end
      default: begin
        a_x = vx[TAG_CUR0]; a_z = vz[TAG_CUR0];
        b_x = vx[TAG_CUR1]; b_z = vz[TAG_CUR1];
        c_x = vx[TAG_CUR2]; c_z = vz[TAG_CUR2];
      end
    endcase
  end

  tspl_area #(
    .COORD_BITS (COORD_BITS)
  ) u_area (
    .clk    (clk),
    .rst    (rst),
    .start  (area_start),
    .a_x    (a_x),
    .a_z    (a_z),
    .b_x    (b_x),
    .b_z    (b_z),
    .c_x    (c_x),
    .c_z    (c_z),
    .p_x    (px_r),
    .p_z    (pz_r),
    .slack  (area_slack),
    .status (area_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ram_re     = 1'b0;
    area_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (cmd == CMD_QUERY)) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
        if (rtag >= TAG_CUR2) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: state_next = ST_START;
      ST_START: begin
        area_start = 1'b1;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (area_st.done) begin
          if (area_st.hit || (trial == TRIAL_PRV)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      area_slack   <= SLACK_RESET;
      cur_tri      <= '0;
      out_valid    <= 1'b0;
      rd_v_q       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_VERTEX_COUNT: vertex_count <= cfg_data[VCOUNT_BITS-1:0];
          REG_AREA_SLACK:   area_slack   <= cfg_data[SLACK_BITS-1:0];
          default: begin
          end
        endcase
      end
      rd_v_q <= ram_re;
      if (out_load) begin
        out_valid <= 1'b1;
        cur_tri   <= res_idx;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rtag_q <= rtag;
    if (rd_v_q) begin
      vx[rtag_q] <= ram_rdata[2*COORD_BITS-1:COORD_BITS];
      vz[rtag_q] <= ram_rdata[COORD_BITS-1:0];
    end
    if (out_load) begin
      inside_res     <= res_hit;
      triangle_index <= res_idx;
    end
    case (state)
      ST_IDLE: begin
        px_r    <= pos_x;
        pz_r    <= pos_z;
        n_r     <= n_eff;
        cur_r   <= cur_eff;
        rd_addr <= cur_eff;
        rtag    <= TAG_CUR0;
        trial   <= TRIAL_CUR;
      end
      ST_RD: begin
        rtag    <= rtag + 3'd1;
        rd_addr <= wrap_inc(rd_addr, n_r);
      end
      ST_TEST: begin
        if (area_st.done) begin
          if (area_st.hit) begin
            res_hit <= 1'b1;
            case (trial)
              TRIAL_NXT: res_idx <= nxt_idx;
              TRIAL_PRV: res_idx <= prv_idx;
              default:   res_idx <= cur_r;
            endcase
          end else begin
            case (trial)
              TRIAL_CUR: trial <= TRIAL_NXT;
              TRIAL_NXT: begin
                trial   <= TRIAL_PRV;
                rd_addr <= prv_idx;
              end
              default: begin
                res_hit <= 1'b0;
                res_idx <= cur_r;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    in_accept && (cmd == CMD_QUERY) |=> in_stall)
    else $error("query did not block the input");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !ram_we)
    else $error("table written during a query");

  assert property (@(posedge clk) disable iff (rst)
    area_st.done |-> (state == ST_TEST))
    else $error("area result outside the test phase");

  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (32'(cur_tri) < 32'(n_r)) && out_valid)
    else $error("current triangle out of range after a query");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result presented without a finished query");

endmodule
